>>> design/srfp_pkg.sv
package srfp_pkg;

    // Input item modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // End-of-reply outcomes
    localparam logic [2:0] OUT_OK         = 3'd0;
    localparam logic [2:0] OUT_NO_REPLY   = 3'd1;
    localparam logic [2:0] OUT_WRONG_ID   = 3'd2;
    localparam logic [2:0] OUT_BAD_LENGTH = 3'd3;
    localparam logic [2:0] OUT_CHECKSUM   = 3'd4;

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] ANY_ID       = 8'hFE;
    localparam logic [8:0] LEN_OVERHEAD = 9'd2;

    localparam int unsigned LIMIT_W     = 4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_ID      = 3'd2,
        PH_LEN     = 3'd3,
        PH_STATUS  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] expected_id;
        logic [7:0] expected_length;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [2:0] outcome;
        logic [7:0] device_status;
    } t_result;

    // End result: status is only reported on a clean reply
    function automatic t_result end_result(input logic [2:0] outcome,
                                           input logic [7:0] status);
        t_result r;
        r               = '0;
        r.result_kind   = KIND_END;
        r.outcome       = outcome;
        r.device_status = (outcome == OUT_OK) ? status : 8'd0;
        return r;
    endfunction

endpackage

>>> design/srfp_step.sv
// Frame parser state and per-item next-state logic.
module srfp_step (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  srfp_pkg::t_item                       i_item,
    input  logic [srfp_pkg::LIMIT_W-1:0]          i_limit,
    output logic                                  o_res_valid,
    output srfp_pkg::t_result                     o_res
);

    srfp_pkg::t_phase r_phase, n_phase;
    logic [srfp_pkg::LIMIT_W-1:0] r_hunt, n_hunt;
    logic       r_prev_ff, n_prev_ff;
    logic [7:0] r_target_id, n_target_id;
    logic [7:0] r_target_len, n_target_len;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_seen, n_seen;
    logic [7:0] r_status, n_status;
    logic [7:0] b;

    assign b = i_item.rx_byte;

    always_comb begin
        n_phase      = r_phase;
        n_hunt       = r_hunt;
        n_prev_ff    = r_prev_ff;
        n_target_id  = r_target_id;
        n_target_len = r_target_len;
        n_sum        = r_sum;
        n_seen       = r_seen;
        n_status     = r_status;
        o_res_valid  = 1'b0;
        o_res        = '0;
        case (i_item.mode)
            srfp_pkg::MODE_START: begin
                n_target_id  = i_item.expected_id;
                n_target_len = i_item.expected_length;
                n_phase      = srfp_pkg::PH_HUNT;
                n_hunt       = '0;
                n_prev_ff    = 1'b0;
                n_sum        = 8'd0;
                n_seen       = 8'd0;
                n_status     = 8'd0;
            end
            srfp_pkg::MODE_BYTE: begin
                case (r_phase)
                    srfp_pkg::PH_HUNT: begin
                        if (b == srfp_pkg::HEADER_BYTE && r_prev_ff) begin
                            n_phase = srfp_pkg::PH_ID;
                        end else begin
                            n_prev_ff = (b == srfp_pkg::HEADER_BYTE);
                            if (r_hunt >= i_limit) begin
                                o_res_valid = 1'b1;
                                o_res = srfp_pkg::end_result(srfp_pkg::OUT_NO_REPLY,
                                                             r_status);
                                n_phase = srfp_pkg::PH_IDLE;
                            end else begin
                                n_hunt = r_hunt + 1'b1;
                            end
                        end
                    end
                    srfp_pkg::PH_ID: begin
                        n_sum = b;
                        if (b != r_target_id && r_target_id != srfp_pkg::ANY_ID) begin
                            o_res_valid = 1'b1;
                            o_res = srfp_pkg::end_result(srfp_pkg::OUT_WRONG_ID,
                                                         r_status);
                            n_phase = srfp_pkg::PH_IDLE;
                        end else begin
                            n_phase = srfp_pkg::PH_LEN;
                        end
                    end
                    srfp_pkg::PH_LEN: begin
                        n_sum = r_sum + b;
                        // 9-bit compare: lengths 254/255 can never match
                        if ({1'b0, b} != ({1'b0, r_target_len} + srfp_pkg::LEN_OVERHEAD))
                        begin
                            o_res_valid = 1'b1;
                            o_res = srfp_pkg::end_result(srfp_pkg::OUT_BAD_LENGTH,
                                                         r_status);
                            n_phase = srfp_pkg::PH_IDLE;
                        end else begin
                            n_phase = srfp_pkg::PH_STATUS;
                        end
                    end
                    srfp_pkg::PH_STATUS: begin
                        n_sum    = r_sum + b;
                        n_status = b;
                        n_seen   = 8'd0;
                        n_phase  = (r_target_len == 8'd0) ? srfp_pkg::PH_CHECK
                                                          : srfp_pkg::PH_PAYLOAD;
                    end
                    srfp_pkg::PH_PAYLOAD: begin
                        n_sum  = r_sum + b;
                        n_seen = r_seen + 8'd1;
                        if (n_seen == r_target_len) begin
                            n_phase = srfp_pkg::PH_CHECK;
                        end
                        o_res_valid        = 1'b1;
                        o_res.result_kind  = srfp_pkg::KIND_PAYLOAD;
                        o_res.payload_byte = b;
                    end
                    srfp_pkg::PH_CHECK: begin
                        o_res_valid = 1'b1;
                        o_res = srfp_pkg::end_result((~r_sum == b) ? srfp_pkg::OUT_OK
                                                                   : srfp_pkg::OUT_CHECKSUM,
                                                     r_status);
                        n_phase = srfp_pkg::PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            srfp_pkg::MODE_TIMEOUT: begin
                if (r_phase != srfp_pkg::PH_IDLE) begin
                    o_res_valid = 1'b1;
                    o_res = srfp_pkg::end_result(srfp_pkg::OUT_NO_REPLY, r_status);
                    n_phase = srfp_pkg::PH_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= srfp_pkg::PH_IDLE;
            r_hunt       <= '0;
            r_prev_ff    <= 1'b0;
            r_target_id  <= 8'd0;
            r_target_len <= 8'd0;
            r_sum        <= 8'd0;
            r_seen       <= 8'd0;
            r_status     <= 8'd0;
        end else if (i_advance) begin
            r_phase      <= n_phase;
            r_hunt       <= n_hunt;
            r_prev_ff    <= n_prev_ff;
            r_target_id  <= n_target_id;
            r_target_len <= n_target_len;
            r_sum        <= n_sum;
            r_seen       <= n_seen;
            r_status     <= n_status;
        end
    end

    // An end result always drops the parser back to idle
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.result_kind == srfp_pkg::KIND_END)
        |=> (r_phase == srfp_pkg::PH_IDLE))
        else $error("end result did not return parser to idle");

    // Payload results only come out of the payload phase
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.result_kind == srfp_pkg::KIND_PAYLOAD)
        |-> (r_phase == srfp_pkg::PH_PAYLOAD))
        else $error("payload result outside payload phase");

    // Payload count never runs past the requested length
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == srfp_pkg::PH_PAYLOAD) |-> (r_seen < r_target_len))
        else $error("payload count overran length");

endmodule

>>> design/srfp_out_reg.sv
// Result register: holds one result until the receiver takes it.
module srfp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  srfp_pkg::t_result i_data,
    input  logic              i_stall,
    output logic              o_ready,
    output logic              o_valid,
    output srfp_pkg::t_result o_data
);

    logic              r_valid, n_valid;
    srfp_pkg::t_result r_data;

    assign o_ready = !r_valid || !i_stall;
    assign n_valid = i_load ? 1'b1 : (r_valid && i_stall);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

>>> design/servo_reply_frame_parser_core.sv
// Servo reply frame parser.
//
// Input channel (i_valid / o_stall, payload i_item): one item per byte event:
// a start item arms the parser with expected ID and payload length, a byte
// item carries one received bus byte, a timeout item ends a pending reply.
// Output channel (o_valid / i_stall, payload o_result): payload bytes are
// streamed as they arrive; one end result per reply gives the outcome and,
// on success, the device status byte. Most items produce no result.
// Configuration: i_cfg_we / i_cfg_data write the header search limit; write
// only while the block is idle.
// Path: an accepted item is held in the input register, parsed, and its
// result is loaded into the result register, which drives o_valid.
// One item per cycle is sustained while the receiver does not stall; the
// feedback loops are the 8-bit running checksum, phase and counter updates.
// Stall: while the receiver stalls a held result, the input register still
// takes one more item; after that o_stall rises until the result drains.
// Reset (synchronous, active low): parser idle, no results pending, search
// limit back to 10.
module servo_reply_frame_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  srfp_pkg::t_item                i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output srfp_pkg::t_result              o_result,
    input  logic                           i_cfg_we,
    input  logic [srfp_pkg::LIMIT_W-1:0]   i_cfg_data
);

    logic [srfp_pkg::LIMIT_W-1:0] r_limit;

    // Input register
    logic            r_in_valid, n_in_valid;
    srfp_pkg::t_item r_in_item;
    logic            in_take;

    // Parse stage
    logic              advance;
    logic              out_ready;
    logic              res_valid;
    srfp_pkg::t_result res;

    assign advance    = r_in_valid && out_ready;
    assign o_stall    = r_in_valid && !advance;
    assign in_take    = i_valid && !o_stall;
    assign n_in_valid = in_take || (r_in_valid && !advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_limit    <= srfp_pkg::LIMIT_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_item;
        end
    end

    srfp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (r_in_item),
        .i_limit     (r_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    srfp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_data  (res),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_data  (o_result)
    );

    // Back-pressure only when the input register is occupied
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("stall raised with empty input register");

    // A held item is not dropped while the result register is blocked
    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_valid && i_stall) |=> r_in_valid)
        else $error("input item lost under output stall");

    // A result loaded from the parse stage shows up on the output next cycle
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res_valid) |=> o_valid)
        else $error("parsed result not presented");

endmodule
